@@ rtl/core/esc_pkg.sv @@
`timescale 1ns / 1ps

package esc_pkg;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] CFG_TEMP_COEFFS  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESS_LOW    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESS_HIGH   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESS_NINE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HUM_COEFFS   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_HUM_PRESENT  = 3'd5;

    localparam int DIV_STEPS = 64;

    localparam logic [31:0] TEMP_X_OFFSET  = 32'd128000;
    localparam logic [31:0] HUM_T_OFFSET   = 32'd76800;
    localparam logic [31:0] HUM_CLAMP_MAX  = 32'd419430400;
    localparam logic [15:0] PRESS_SCALE    = 16'd3125;

    typedef struct packed {
        logic [19:0] raw_pressure;
        logic [19:0] raw_temperature;
        logic [15:0] raw_humidity;
    } in_t;

    typedef struct packed {
        logic signed [31:0] temperature_centi;
        logic [31:0]        pressure_q24_8;
        logic [16:0]        humidity_q22_10;
    } out_t;

    typedef struct packed {
        logic [31:0] tf;
        logic [31:0] temp;
        logic [19:0] rp;
        logic [15:0] rh;
    } temp_res_t;

    typedef struct packed {
        logic [31:0] tf;
        logic [31:0] temp;
        logic [19:0] rp;
        logic [16:0] hum;
    } hum_res_t;

    typedef struct packed {
        logic [63:0] n;
        logic [63:0] d;
        logic [31:0] temp;
        logic [16:0] hum;
    } pre_res_t;

    typedef struct packed {
        logic [63:0] q;
        logic        dz;
        logic [31:0] temp;
        logic [16:0] hum;
    } div_res_t;

    function automatic logic [31:0] asr32(logic [31:0] v, logic [4:0] s);
        logic signed [31:0] sv;
        sv = v;
        sv = sv >>> s;
        return sv;
    endfunction

    function automatic logic [63:0] asr64(logic [63:0] v, logic [5:0] s);
        logic signed [63:0] sv;
        sv = v;
        sv = sv >>> s;
        return sv;
    endfunction

    // 64 x 16 unsigned, low 64 bits, from two 32 x 16 partial products
    function automatic logic [63:0] mul64u16(logic [63:0] a, logic [15:0] b);
        logic [47:0] pl;
        logic [47:0] ph;
        pl = a[31:0] * b;
        ph = a[63:32] * b;
        return {16'd0, pl} + {ph[31:0], 32'd0};
    endfunction

    function automatic logic [63:0] mul64s16(logic [63:0] a, logic [15:0] b);
        logic [63:0] corr;
        corr = b[15] ? {a[47:0], 16'd0} : 64'd0;
        return mul64u16(a, b) - corr;
    endfunction

endpackage

@@ rtl/core/esc_temp.sv @@
`timescale 1ns / 1ps

module esc_temp (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  logic                in_valid,
    input  esc_pkg::in_t        in_data,
    input  logic [47:0]         temperature_coeffs,
    output logic                out_valid,
    output esc_pkg::temp_res_t  out_data
);

    logic [31:0] t1;
    logic [31:0] t2;
    logic [31:0] t3;
    logic [4:0]  v_reg;
    logic [35:0] side_reg [0:3];
    logic [31:0] a_reg, b_reg;
    logic [31:0] m1_reg, m2_reg;
    logic [31:0] m1s_reg, m3_reg;
    logic [31:0] tf_reg;
    esc_pkg::temp_res_t out_reg;
    esc_pkg::temp_res_t out_next;

    assign t1 = {16'd0, temperature_coeffs[15:0]};
    assign t2 = {{16{temperature_coeffs[31]}}, temperature_coeffs[31:16]};
    assign t3 = {{16{temperature_coeffs[47]}}, temperature_coeffs[47:32]};

    always_comb begin
        out_next.tf   = tf_reg;
        out_next.temp = esc_pkg::asr32(tf_reg * 32'd5 + 32'd128, 5'd8);
        out_next.rp   = side_reg[3][35:16];
        out_next.rh   = side_reg[3][15:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[3:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_reg <= {15'd0, in_data.raw_temperature[19:3]} - {t1[30:0], 1'b0};
            b_reg <= {16'd0, in_data.raw_temperature[19:4]} - t1;
            side_reg[0] <= {in_data.raw_pressure, in_data.raw_humidity};

            m1_reg <= a_reg * t2;
            m2_reg <= b_reg * b_reg;
            side_reg[1] <= side_reg[0];

            m1s_reg <= esc_pkg::asr32(m1_reg, 5'd11);
            m3_reg  <= esc_pkg::asr32(m2_reg, 5'd12) * t3;
            side_reg[2] <= side_reg[1];

            tf_reg <= m1s_reg + esc_pkg::asr32(m3_reg, 5'd14);
            side_reg[3] <= side_reg[2];

            out_reg <= out_next;
        end
    end

    assign out_valid = v_reg[4];
    assign out_data  = out_reg;

endmodule

@@ rtl/core/esc_hum.sv @@
`timescale 1ns / 1ps

module esc_hum (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  logic                in_valid,
    input  esc_pkg::temp_res_t  in_data,
    input  logic [63:0]         humidity_coeffs,
    input  logic                humidity_present,
    output logic                out_valid,
    output esc_pkg::hum_res_t   out_data
);

    typedef struct packed {
        logic [31:0] tf;
        logic [31:0] temp;
        logic [19:0] rp;
    } side_t;

    logic [31:0] h1, h2, h3, h4, h5, h6;
    logic [31:0] v;
    logic [7:0]  v_reg;
    side_t       side_reg [0:6];
    logic [31:0] e1a_reg, e2m_reg, e3m_reg;
    logic [31:0] e1_reg [2:4];
    logic [31:0] e2_reg, e3_reg, e4m_reg, e5m_reg;
    logic [31:0] vh_reg [5:7];
    logic [31:0] s;
    logic [31:0] ss_reg, t_reg;
    logic [31:0] vf;
    logic [31:0] clamped;
    esc_pkg::hum_res_t out_reg;
    esc_pkg::hum_res_t out_next;

    assign h1 = {24'd0, humidity_coeffs[7:0]};
    assign h2 = {{16{humidity_coeffs[23]}}, humidity_coeffs[23:8]};
    assign h3 = {24'd0, humidity_coeffs[31:24]};
    assign h4 = {{20{humidity_coeffs[43]}}, humidity_coeffs[43:32]};
    assign h5 = {{20{humidity_coeffs[55]}}, humidity_coeffs[55:44]};
    assign h6 = {{24{humidity_coeffs[63]}}, humidity_coeffs[63:56]};

    assign v = in_data.tf - esc_pkg::HUM_T_OFFSET;
    assign s = esc_pkg::asr32(vh_reg[5], 5'd15);

    always_comb begin
        vf = vh_reg[7] - esc_pkg::asr32(t_reg, 5'd4);
        if (vf[31]) begin
            clamped = '0;
        end else if (vf > esc_pkg::HUM_CLAMP_MAX) begin
            clamped = esc_pkg::HUM_CLAMP_MAX;
        end else begin
            clamped = vf;
        end
        out_next.tf   = side_reg[6].tf;
        out_next.temp = side_reg[6].temp;
        out_next.rp   = side_reg[6].rp;
        out_next.hum  = humidity_present ? clamped[28:12] : 17'd0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[6:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            e1a_reg <= {2'd0, in_data.rh, 14'd0} - {h4[11:0], 20'd0} - h5 * v;
            e2m_reg <= v * h6;
            e3m_reg <= v * h3;
            side_reg[0] <= '{tf: in_data.tf, temp: in_data.temp, rp: in_data.rp};

            e1_reg[2] <= esc_pkg::asr32(e1a_reg + 32'd16384, 5'd15);
            e2_reg    <= esc_pkg::asr32(e2m_reg, 5'd10);
            e3_reg    <= esc_pkg::asr32(e3m_reg, 5'd11) + 32'd32768;
            side_reg[1] <= side_reg[0];

            e1_reg[3] <= e1_reg[2];
            e4m_reg   <= e2_reg * e3_reg;
            side_reg[2] <= side_reg[1];

            e1_reg[4] <= e1_reg[3];
            e5m_reg   <= (esc_pkg::asr32(e4m_reg, 5'd10) + 32'd2097152) * h2 + 32'd8192;
            side_reg[3] <= side_reg[2];

            vh_reg[5] <= e1_reg[4] * esc_pkg::asr32(e5m_reg, 5'd14);
            side_reg[4] <= side_reg[3];

            vh_reg[6] <= vh_reg[5];
            ss_reg    <= s * s;
            side_reg[5] <= side_reg[4];

            vh_reg[7] <= vh_reg[6];
            t_reg     <= esc_pkg::asr32(ss_reg, 5'd7) * h1;
            side_reg[6] <= side_reg[5];

            out_reg <= out_next;
        end
    end

    assign out_valid = v_reg[7];
    assign out_data  = out_reg;

endmodule

@@ rtl/core/esc_pre.sv @@
`timescale 1ns / 1ps

module esc_pre (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  logic               in_valid,
    input  esc_pkg::hum_res_t  in_data,
    input  logic [63:0]        pressure_coeffs_low,
    input  logic [63:0]        pressure_coeffs_high,
    output logic               out_valid,
    output esc_pkg::pre_res_t  out_data
);

    typedef struct packed {
        logic [19:0] rp;
        logic [31:0] temp;
        logic [16:0] hum;
    } side_t;

    logic [15:0]        p1;
    logic signed [15:0] p2s, p5s;
    logic [63:0]        p4;
    logic [6:0]         v_reg;
    side_t              side_reg [0:5];
    logic [63:0]        x64;
    logic signed [32:0] x_reg;
    logic signed [65:0] xsq_full;
    logic signed [48:0] xp5_full, xp2_full;
    logic [63:0]        xs_reg;
    logic [63:0]        xp5_reg [2:3];
    logic [63:0]        xp2_reg [2:3];
    logic [63:0]        xsp6_reg, xsp3_reg;
    logic [63:0]        v2_reg [4:5];
    logic [63:0]        v1a_reg, v1p_reg;
    logic [63:0]        d_reg, diff_reg;
    logic [20:0]        pm;
    esc_pkg::pre_res_t  out_reg;

    assign p1  = pressure_coeffs_low[15:0];
    assign p2s = pressure_coeffs_low[31:16];
    assign p4  = {{48{pressure_coeffs_low[63]}}, pressure_coeffs_low[63:48]};
    assign p5s = pressure_coeffs_high[15:0];

    assign x64 = {{32{in_data.tf[31]}}, in_data.tf} - {32'd0, esc_pkg::TEMP_X_OFFSET};
    assign xsq_full = x_reg * x_reg;
    assign xp5_full = x_reg * p5s;
    assign xp2_full = x_reg * p2s;
    assign pm = 21'd1048576 - {1'b0, side_reg[4].rp};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[5:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg <= x64[32:0];
            side_reg[0] <= '{rp: in_data.rp, temp: in_data.temp, hum: in_data.hum};

            xs_reg     <= xsq_full[63:0];
            xp5_reg[2] <= {{15{xp5_full[48]}}, xp5_full};
            xp2_reg[2] <= {{15{xp2_full[48]}}, xp2_full};
            side_reg[1] <= side_reg[0];

            xsp6_reg   <= esc_pkg::mul64s16(xs_reg, pressure_coeffs_high[31:16]);
            xsp3_reg   <= esc_pkg::mul64s16(xs_reg, pressure_coeffs_low[47:32]);
            xp5_reg[3] <= xp5_reg[2];
            xp2_reg[3] <= xp2_reg[2];
            side_reg[2] <= side_reg[1];

            v2_reg[4] <= xsp6_reg + {xp5_reg[3][46:0], 17'd0} + {p4[28:0], 35'd0};
            v1a_reg   <= esc_pkg::asr64(xsp3_reg, 6'd8) + {xp2_reg[3][51:0], 12'd0};
            side_reg[3] <= side_reg[2];

            v2_reg[5] <= v2_reg[4];
            v1p_reg   <= esc_pkg::mul64u16(64'h0000_8000_0000_0000 + v1a_reg, p1);
            side_reg[4] <= side_reg[3];

            d_reg    <= esc_pkg::asr64(v1p_reg, 6'd33);
            diff_reg <= {12'd0, pm, 31'd0} - v2_reg[5];
            side_reg[5] <= side_reg[4];

            out_reg.n    <= esc_pkg::mul64u16(diff_reg, esc_pkg::PRESS_SCALE);
            out_reg.d    <= d_reg;
            out_reg.temp <= side_reg[5].temp;
            out_reg.hum  <= side_reg[5].hum;
        end
    end

    assign out_valid = v_reg[6];
    assign out_data  = out_reg;

endmodule

@@ rtl/core/esc_div.sv @@
`timescale 1ns / 1ps

module esc_div (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  logic               in_valid,
    input  esc_pkg::pre_res_t  in_data,
    output logic               out_valid,
    output esc_pkg::div_res_t  out_data
);

    typedef struct packed {
        logic [63:0] rem;
        logic [63:0] nq;
        logic [63:0] md;
        logic        neg;
        logic        dz;
        logic [31:0] temp;
        logic [16:0] hum;
    } stage_t;

    // one restoring step: dividend bits shift out of nq, quotient bits in
    function automatic stage_t div_step(stage_t s);
        stage_t      r;
        logic [64:0] sh;
        logic [64:0] diff;
        r    = s;
        sh   = {s.rem, s.nq[63]};
        diff = sh - {1'b0, s.md};
        if (!diff[64]) begin
            r.rem = diff[63:0];
            r.nq  = {s.nq[62:0], 1'b1};
        end else begin
            r.rem = sh[63:0];
            r.nq  = {s.nq[62:0], 1'b0};
        end
        return r;
    endfunction

    logic [esc_pkg::DIV_STEPS+1:0] v_reg;
    stage_t                        st_reg [0:esc_pkg::DIV_STEPS];
    stage_t                        st_next;
    esc_pkg::div_res_t             out_reg;
    stage_t                        last;

    always_comb begin
        st_next.rem  = '0;
        st_next.nq   = in_data.n[63] ? 64'd0 - in_data.n : in_data.n;
        st_next.md   = in_data.d[63] ? 64'd0 - in_data.d : in_data.d;
        st_next.neg  = in_data.n[63] ^ in_data.d[63];
        st_next.dz   = (in_data.d == 64'd0);
        st_next.temp = in_data.temp;
        st_next.hum  = in_data.hum;
    end

    assign last = st_reg[esc_pkg::DIV_STEPS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[esc_pkg::DIV_STEPS:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            st_reg[0]    <= st_next;
            out_reg.q    <= last.neg ? 64'd0 - last.nq : last.nq;
            out_reg.dz   <= last.dz;
            out_reg.temp <= last.temp;
            out_reg.hum  <= last.hum;
        end
    end

    for (genvar k = 0; k < esc_pkg::DIV_STEPS; k++) begin : g_step
        always_ff @(posedge aclk) begin
            if (en) begin
                st_reg[k+1] <= div_step(st_reg[k]);
            end
        end
    end

    assign out_valid = v_reg[esc_pkg::DIV_STEPS+1];
    assign out_data  = out_reg;

endmodule

@@ rtl/core/esc_post.sv @@
`timescale 1ns / 1ps

module esc_post (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  logic               in_valid,
    input  esc_pkg::div_res_t  in_data,
    input  logic [63:0]        pressure_coeffs_high,
    input  logic [15:0]        pressure_coeff_nine,
    output logic               out_valid,
    output esc_pkg::out_t      out_data
);

    typedef struct packed {
        logic        dz;
        logic [31:0] temp;
        logic [16:0] hum;
    } side_t;

    logic [3:0]    v_reg;
    side_t         side_reg [0:2];
    logic [63:0]   qq;
    logic [63:0]   p_reg [0:2];
    logic [63:0]   ll_reg;
    logic [31:0]   lh_reg;
    logic [63:0]   p8p_reg;
    logic [63:0]   qsq_reg;
    logic [63:0]   v2_reg [1:2];
    logic [63:0]   p9q_reg;
    logic [63:0]   p7;
    logic [63:0]   pf;
    esc_pkg::out_t out_reg;
    esc_pkg::out_t out_next;

    assign qq = esc_pkg::asr64(in_data.q, 6'd13);
    assign p7 = {{48{pressure_coeffs_high[47]}}, pressure_coeffs_high[47:32]};

    always_comb begin
        pf = esc_pkg::asr64(p_reg[2] + esc_pkg::asr64(p9q_reg, 6'd25) + v2_reg[2], 6'd8)
           + {p7[59:0], 4'd0};
        out_next.temperature_centi = side_reg[2].temp;
        out_next.pressure_q24_8    = side_reg[2].dz ? 32'd0 : pf[31:0];
        out_next.humidity_q22_10   = side_reg[2].hum;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p_reg[0] <= in_data.q;
            ll_reg   <= qq[31:0] * qq[31:0];
            lh_reg   <= qq[31:0] * qq[63:32];
            p8p_reg  <= esc_pkg::mul64s16(in_data.q, pressure_coeffs_high[63:48]);
            side_reg[0] <= '{dz: in_data.dz, temp: in_data.temp, hum: in_data.hum};

            p_reg[1]  <= p_reg[0];
            qsq_reg   <= ll_reg + {lh_reg[30:0], 33'd0};
            v2_reg[1] <= esc_pkg::asr64(p8p_reg, 6'd19);
            side_reg[1] <= side_reg[0];

            p_reg[2]  <= p_reg[1];
            v2_reg[2] <= v2_reg[1];
            p9q_reg   <= esc_pkg::mul64s16(qsq_reg, pressure_coeff_nine);
            side_reg[2] <= side_reg[1];

            out_reg <= out_next;
        end
    end

    assign out_valid = v_reg[3];
    assign out_data  = out_reg;

endmodule

@@ rtl/core/env_sensor_compensation_top.sv @@
`timescale 1ns / 1ps
// Depth: 90 register stages between an accepted request and its result on m_data.
// Throughput: one request per cycle unless m_ready stalls the output; the 64-stage
// quotient pipeline sets the depth. A stall at m_ready freezes the whole pipeline;
// a one-entry input skid takes one more request meanwhile.
// Reset (aresetn low, synchronous) clears valid bits, the skid valid flag and coefficients to 0.
module env_sensor_compensation_top (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  esc_pkg::in_t                    s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output esc_pkg::out_t                   m_data,
    input  logic                            cfg_wr_en,
    input  logic [esc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [esc_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

    logic [47:0] temp_coeffs_reg;
    logic [63:0] press_low_reg;
    logic [63:0] press_high_reg;
    logic [15:0] press_nine_reg;
    logic [63:0] hum_coeffs_reg;
    logic        hum_present_reg;

    logic         skid_valid_reg;
    logic         skid_valid_next;
    esc_pkg::in_t skid_reg;
    logic         en;
    logic         in_valid;
    esc_pkg::in_t in_data;

    logic                 temp_valid, hum_valid, pre_valid, div_valid;
    esc_pkg::temp_res_t   temp_res;
    esc_pkg::hum_res_t    hum_res;
    esc_pkg::pre_res_t    pre_res;
    esc_pkg::div_res_t    div_res;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            temp_coeffs_reg <= '0;
            press_low_reg   <= '0;
            press_high_reg  <= '0;
            press_nine_reg  <= '0;
            hum_coeffs_reg  <= '0;
            hum_present_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                esc_pkg::CFG_TEMP_COEFFS: begin
                    temp_coeffs_reg <= cfg_wdata[47:0];
                end
                esc_pkg::CFG_PRESS_LOW: begin
                    press_low_reg <= cfg_wdata;
                end
                esc_pkg::CFG_PRESS_HIGH: begin
                    press_high_reg <= cfg_wdata;
                end
                esc_pkg::CFG_PRESS_NINE: begin
                    press_nine_reg <= cfg_wdata[15:0];
                end
                esc_pkg::CFG_HUM_COEFFS: begin
                    hum_coeffs_reg <= cfg_wdata;
                end
                esc_pkg::CFG_HUM_PRESENT: begin
                    hum_present_reg <= cfg_wdata[0];
                end
                default: begin
                end
            endcase
        end
    end

    assign en       = !m_valid || m_ready;
    assign s_ready  = !skid_valid_reg;
    assign in_valid = skid_valid_reg || s_valid;
    assign in_data  = skid_valid_reg ? skid_reg : s_data;

    always_comb begin
        skid_valid_next = skid_valid_reg;
        if (en) begin
            skid_valid_next = 1'b0;
        end else if (s_valid && s_ready) begin
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            skid_valid_reg <= 1'b0;
        end else begin
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!en && s_valid && s_ready) begin
            skid_reg <= s_data;
        end
    end

    esc_temp u_temp (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .en                 (en),
        .in_valid           (in_valid),
        .in_data            (in_data),
        .temperature_coeffs (temp_coeffs_reg),
        .out_valid          (temp_valid),
        .out_data           (temp_res)
    );

    esc_hum u_hum (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .en               (en),
        .in_valid         (temp_valid),
        .in_data          (temp_res),
        .humidity_coeffs  (hum_coeffs_reg),
        .humidity_present (hum_present_reg),
        .out_valid        (hum_valid),
        .out_data         (hum_res)
    );

    esc_pre u_pre (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .en                   (en),
        .in_valid             (hum_valid),
        .in_data              (hum_res),
        .pressure_coeffs_low  (press_low_reg),
        .pressure_coeffs_high (press_high_reg),
        .out_valid            (pre_valid),
        .out_data             (pre_res)
    );

    esc_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (pre_valid),
        .in_data   (pre_res),
        .out_valid (div_valid),
        .out_data  (div_res)
    );

    esc_post u_post (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .en                   (en),
        .in_valid             (div_valid),
        .in_data              (div_res),
        .pressure_coeffs_high (press_high_reg),
        .pressure_coeff_nine  (press_nine_reg),
        .out_valid            (m_valid),
        .out_data             (m_data)
    );

endmodule

@@ rtl/core/esc_checker.sv @@
`timescale 1ns / 1ps

module esc_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_valid,
    input logic                            s_ready,
    input logic                            m_valid,
    input logic                            m_ready,
    input esc_pkg::out_t                   m_data
);

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("outputs not idle after reset");

    a_ready_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(s_ready) |-> $past(m_valid && !m_ready && s_valid))
        else $error("s_ready dropped without an output stall");

    a_skid_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready && (!m_valid || m_ready) |=> s_ready)
        else $error("skid did not drain while pipeline moved");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result changed");

endmodule

bind env_sensor_compensation_top esc_checker u_esc_checker (.*);

@@ tb/sv/env_sensor_compensation_top_tb.sv @@
`timescale 1ns / 1ps

module env_sensor_compensation_top_tb;

    localparam int CLK_PERIOD = 12;
    localparam int CYCLE_LIMIT = 1500000;
    localparam int DRAIN_CYCLES = 120;

    logic                           aclk;
    logic                           aresetn;
    logic                           s_valid;
    logic                           s_ready;
    esc_pkg::in_t                   s_data;
    logic                           m_valid;
    logic                           m_ready;
    esc_pkg::out_t                  m_data;
    logic                           cfg_wr_en;
    logic [esc_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [esc_pkg::CFG_DATA_W-1:0] cfg_wdata;

    // shadow copy of the coefficient registers
    logic [47:0] temp_coeffs;
    logic [63:0] press_lo;
    logic [63:0] press_hi;
    logic [15:0] press_nine;
    logic [63:0] hum_coeffs;
    logic        hum_enable;

    esc_pkg::out_t expected_q[$];
    int   error_count;
    int   cycle_count;
    bit   idle_on;
    int   hold_cycles;
    int   stall_left;

    env_sensor_compensation_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #(CLK_PERIOD / 2) aclk = ~aclk;
    end

    function automatic logic [31:0] sra32(logic [31:0] v, int s);
        return $unsigned($signed(v) >>> s);
    endfunction

    function automatic logic [63:0] sra64(logic [63:0] v, int s);
        return $unsigned($signed(v) >>> s);
    endfunction

    function automatic logic [63:0] sx16(logic [15:0] v);
        return {{48{v[15]}}, v};
    endfunction

    // signed 64-bit quotient, truncating toward zero, wrapping
    function automatic logic [63:0] quotient64(logic [63:0] n, logic [63:0] d);
        logic [63:0] mn;
        logic [63:0] md;
        logic [63:0] q;
        mn = n[63] ? 64'd0 - n : n;
        md = d[63] ? 64'd0 - d : d;
        q = mn / md;
        return (n[63] != d[63]) ? 64'd0 - q : q;
    endfunction

    function automatic esc_pkg::out_t compensate(esc_pkg::in_t raw);
        esc_pkg::out_t r;
        logic [31:0] rp, rt, rh, t1, t2, t3, a, b, tf, temp;
        logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
        logic [63:0] x, xs, v1, v2, p, q, w1, w2;
        logic [31:0] h1, h2, h3, h4, h5, h6, v, e1, e2, e3, e4, e5, s;
        rp = {12'd0, raw.raw_pressure};
        rt = {12'd0, raw.raw_temperature};
        rh = {16'd0, raw.raw_humidity};
        t1 = {16'd0, temp_coeffs[15:0]};
        t2 = {{16{temp_coeffs[31]}}, temp_coeffs[31:16]};
        t3 = {{16{temp_coeffs[47]}}, temp_coeffs[47:32]};

        a = (rt >> 3) - (t1 << 1);
        b = (rt >> 4) - t1;
        v = b * b;
        tf = sra32(a * t2, 11) + sra32(sra32(v, 12) * t3, 14);
        temp = sra32(tf * 32'd5 + 32'd128, 8);

        p1 = {48'd0, press_lo[15:0]};
        p2 = sx16(press_lo[31:16]);
        p3 = sx16(press_lo[47:32]);
        p4 = sx16(press_lo[63:48]);
        p5 = sx16(press_hi[15:0]);
        p6 = sx16(press_hi[31:16]);
        p7 = sx16(press_hi[47:32]);
        p8 = sx16(press_hi[63:48]);
        p9 = sx16(press_nine);

        x = {{32{tf[31]}}, tf} - 64'd128000;
        xs = x * x;
        v2 = xs * p6 + ((x * p5) << 17) + (p4 << 35);
        v1 = sra64(xs * p3, 8) + ((x * p2) << 12);
        v1 = sra64(((64'd1 << 47) + v1) * p1, 33);
        if (v1 == 64'd0) begin
            p = 64'd0;
        end else begin
            p = 64'd1048576 - {32'd0, rp};
            p = quotient64(((p << 31) - v2) * 64'd3125, v1);
            q = sra64(p, 13);
            w1 = sra64(p9 * (q * q), 25);
            w2 = sra64(p8 * p, 19);
            p = sra64(p + w1 + w2, 8) + (p7 << 4);
        end

        r.temperature_centi = temp;
        r.pressure_q24_8 = p[31:0];
        r.humidity_q22_10 = '0;
        if (hum_enable) begin
            h1 = {24'd0, hum_coeffs[7:0]};
            h2 = {{16{hum_coeffs[23]}}, hum_coeffs[23:8]};
            h3 = {24'd0, hum_coeffs[31:24]};
            h4 = {{20{hum_coeffs[43]}}, hum_coeffs[43:32]};
            h5 = {{20{hum_coeffs[55]}}, hum_coeffs[55:44]};
            h6 = {{24{hum_coeffs[63]}}, hum_coeffs[63:56]};
            v = tf - 32'd76800;
            e1 = (rh << 14) - (h4 << 20) - h5 * v;
            e1 = sra32(e1 + 32'd16384, 15);
            e2 = sra32(v * h6, 10);
            e3 = sra32(v * h3, 11) + 32'd32768;
            e4 = sra32(e2 * e3, 10) + 32'd2097152;
            e5 = sra32(e4 * h2 + 32'd8192, 14);
            v = e1 * e5;
            s = sra32(v, 15);
            v = v - sra32(sra32(s * s, 7) * h1, 4);
            if (v[31]) begin
                v = 32'd0;
            end else if (v > esc_pkg::HUM_CLAMP_MAX) begin
                v = esc_pkg::HUM_CLAMP_MAX;
            end
            r.humidity_q22_10 = v[28:12];
        end
        return r;
    endfunction

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // result checker
    always @(posedge aclk) begin
        esc_pkg::out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_q.size() == 0) begin
                error_count++;
                $error("result with no request pending");
            end else begin
                want = expected_q.pop_front();
                if (m_data.temperature_centi !== want.temperature_centi) begin
                    error_count++;
                    $error("temperature_centi: expected %0d, actual %0d",
                           want.temperature_centi, m_data.temperature_centi);
                end
                if (m_data.pressure_q24_8 !== want.pressure_q24_8) begin
                    error_count++;
                    $error("pressure_q24_8: expected %0h, actual %0h",
                           want.pressure_q24_8, m_data.pressure_q24_8);
                end
                if (m_data.humidity_q22_10 !== want.humidity_q22_10) begin
                    error_count++;
                    $error("humidity_q22_10: expected %0d, actual %0d",
                           want.humidity_q22_10, m_data.humidity_q22_10);
                end
            end
        end
    end

    // result side ready, with random stall bursts and long hold-offs
    always @(negedge aclk) begin
        if (hold_cycles > 0) begin
            m_ready <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end else if (stall_left > 0) begin
            m_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            m_ready <= 1'b1;
            if (idle_on && $urandom_range(0, 7) == 0) begin
                stall_left <= $urandom_range(1, 11);
            end
        end
    end

    task automatic send_request(esc_pkg::in_t d);
        int gap;
        @(negedge aclk);
        s_valid = 1'b1;
        s_data = d;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        expected_q.push_back(compensate(d));
        if (idle_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 11);
            @(negedge aclk);
            s_valid = 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
    endtask

    task automatic finish_sending();
        @(negedge aclk);
        s_valid = 1'b0;
    endtask

    task automatic wait_drain();
        finish_sending();
        while (expected_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(logic [esc_pkg::CFG_IDX_W-1:0] idx, logic [63:0] val);
        @(negedge aclk);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_wdata = val;
        case (idx)
            esc_pkg::CFG_TEMP_COEFFS: temp_coeffs = val[47:0];
            esc_pkg::CFG_PRESS_LOW:   press_lo = val;
            esc_pkg::CFG_PRESS_HIGH:  press_hi = val;
            esc_pkg::CFG_PRESS_NINE:  press_nine = val[15:0];
            esc_pkg::CFG_HUM_COEFFS:  hum_coeffs = val;
            esc_pkg::CFG_HUM_PRESENT: hum_enable = val[0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_wr_en = 1'b0;
    endtask

    function automatic logic [15:0] jitter(int base, int span);
        return 16'(base + $urandom_range(0, 2 * span) - span);
    endfunction

    task automatic load_typical();
        write_reg(esc_pkg::CFG_TEMP_COEFFS, {16'(-1000), 16'(26435), 16'(27504)});
        write_reg(esc_pkg::CFG_PRESS_LOW,
                  {16'(2855), 16'(3024), 16'(-10685), 16'(36477)});
        write_reg(esc_pkg::CFG_PRESS_HIGH, {16'(-14600), 16'(15500), 16'(-7), 16'(140)});
        write_reg(esc_pkg::CFG_PRESS_NINE, 64'(16'(6000)));
        write_reg(esc_pkg::CFG_HUM_COEFFS,
                  {8'(30), 12'(50), 12'(313), 8'(0), 16'(362), 8'(75)});
        write_reg(esc_pkg::CFG_HUM_PRESENT, 64'd1);
    endtask

    task automatic load_random(bit plausible);
        if (plausible) begin
            write_reg(esc_pkg::CFG_TEMP_COEFFS,
                      {jitter(-1000, 500), jitter(26435, 2000), jitter(27504, 2000)});
            write_reg(esc_pkg::CFG_PRESS_LOW, {jitter(2855, 1000), jitter(3024, 500),
                                               jitter(-10685, 1000), jitter(36477, 2000)});
            write_reg(esc_pkg::CFG_PRESS_HIGH, {jitter(-14600, 1000), jitter(15500, 1000),
                                                jitter(-7, 7), jitter(140, 60)});
            write_reg(esc_pkg::CFG_PRESS_NINE, 64'(jitter(6000, 1000)));
            write_reg(esc_pkg::CFG_HUM_COEFFS,
                      {8'($urandom_range(0, 60)), 12'(jitter(50, 20)),
                       12'(jitter(313, 60)), 8'($urandom_range(0, 255)),
                       jitter(362, 60), 8'($urandom_range(0, 255))});
        end else begin
            write_reg(esc_pkg::CFG_TEMP_COEFFS, {$urandom, $urandom});
            write_reg(esc_pkg::CFG_PRESS_LOW, {$urandom, $urandom});
            write_reg(esc_pkg::CFG_PRESS_HIGH, {$urandom, $urandom});
            write_reg(esc_pkg::CFG_PRESS_NINE, {$urandom, $urandom});
            write_reg(esc_pkg::CFG_HUM_COEFFS, {$urandom, $urandom});
        end
        write_reg(esc_pkg::CFG_HUM_PRESENT, {$urandom, $urandom});
    endtask

    function automatic esc_pkg::in_t random_raw();
        esc_pkg::in_t d;
        d.raw_pressure = 20'($urandom);
        d.raw_temperature = 20'($urandom);
        d.raw_humidity = 16'($urandom);
        if ($urandom_range(0, 3) == 0) begin
            // realistic readings around room conditions
            d.raw_pressure = 20'($urandom_range(300000, 500000));
            d.raw_temperature = 20'($urandom_range(450000, 600000));
            d.raw_humidity = 16'($urandom_range(20000, 40000));
        end
        return d;
    endfunction

    task automatic send_random(int count);
        repeat (count) send_request(random_raw());
    endtask

    task automatic test_reset_values();
        send_request('{20'd0, 20'd0, 16'd0});
        send_request('{20'hFFFFF, 20'hFFFFF, 16'hFFFF});
        send_request('{20'd415148, 20'd519888, 16'd30000});
        wait_drain();
    endtask

    task automatic test_typical_extremes();
        load_typical();
        send_request('{20'd0, 20'd0, 16'd0});
        send_request('{20'hFFFFF, 20'hFFFFF, 16'hFFFF});
        send_request('{20'd0, 20'hFFFFF, 16'd0});
        send_request('{20'hFFFFF, 20'd0, 16'hFFFF});
        send_request('{20'd415148, 20'd519888, 16'd30000});
        send_request('{20'd415148, 20'd519888, 16'd0});
        send_request('{20'd415148, 20'd519888, 16'hFFFF});
        send_request('{20'h80000, 20'h80000, 16'h8000});
        wait_drain();
        // humidity off, and writes to unused indexes are dropped
        write_reg(esc_pkg::CFG_HUM_PRESENT, 64'd0);
        write_reg(3'd6, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(3'd7, 64'hFFFF_FFFF_FFFF_FFFF);
        send_request('{20'd415148, 20'd519888, 16'd30000});
        send_request('{20'hFFFFF, 20'hFFFFF, 16'hFFFF});
        wait_drain();
    endtask

    task automatic test_coeff_extremes();
        write_reg(esc_pkg::CFG_TEMP_COEFFS, 64'h0000_FFFF_FFFF_FFFF);
        write_reg(esc_pkg::CFG_PRESS_LOW, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(esc_pkg::CFG_PRESS_HIGH, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(esc_pkg::CFG_PRESS_NINE, 64'h0000_0000_0000_FFFF);
        write_reg(esc_pkg::CFG_HUM_COEFFS, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(esc_pkg::CFG_HUM_PRESENT, 64'd1);
        send_request('{20'd0, 20'd0, 16'd0});
        send_request('{20'hFFFFF, 20'hFFFFF, 16'hFFFF});
        send_request('{20'h12345, 20'h6789A, 16'hBCDE});
        wait_drain();
        write_reg(esc_pkg::CFG_TEMP_COEFFS, {16'h7FFF, 16'h8000, 16'hFFFF});
        write_reg(esc_pkg::CFG_PRESS_LOW, {16'h7FFF, 16'h7FFF, 16'h8000, 16'hFFFF});
        write_reg(esc_pkg::CFG_PRESS_HIGH, {16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF});
        write_reg(esc_pkg::CFG_PRESS_NINE, 64'h0000_0000_0000_8000);
        write_reg(esc_pkg::CFG_HUM_COEFFS,
                  {8'h7F, 12'h800, 12'h7FF, 8'hFF, 16'h8000, 8'hFF});
        send_request('{20'd0, 20'hFFFFF, 16'hFFFF});
        send_request('{20'hFFFFF, 20'd0, 16'd0});
        send_request('{20'h55555, 20'hAAAAA, 16'h5555});
        wait_drain();
        // P1 of zero makes the pressure divisor zero
        write_reg(esc_pkg::CFG_PRESS_LOW, 64'hFFFF_FFFF_FFFF_0000);
        send_request('{20'h12345, 20'd519888, 16'd30000});
        wait_drain();
    endtask

    task automatic test_random_settings();
        for (int ph = 0; ph < 6; ph++) begin
            idle_on = (ph != 2);
            load_random(ph % 2 == 0);
            send_random(160);
            wait_drain();
        end
    endtask

    task automatic test_backpressure();
        idle_on = 1'b0;
        load_random(1'b1);
        @(negedge aclk);
        hold_cycles = 400;
        send_random(150);
        wait_drain();
    endtask

    task automatic test_final_no_idle();
        idle_on = 1'b0;
        load_random(1'b1);
        send_random(180);
        wait_drain();
    endtask

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        m_ready = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        temp_coeffs = '0;
        press_lo = '0;
        press_hi = '0;
        press_nine = '0;
        hum_coeffs = '0;
        hum_enable = 1'b0;
        error_count = 0;
        cycle_count = 0;
        idle_on = 1'b1;
        hold_cycles = 0;
        stall_left = 0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_reset_values();
        test_typical_extremes();
        test_coeff_extremes();
        test_random_settings();
        test_backpressure();
        test_final_no_idle();

        if (expected_q.size() != 0) begin
            error_count++;
            $error("%0d results never arrived", expected_q.size());
        end
        if (error_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

@@ env_sensor_compensation_top.f @@
rtl/core/esc_pkg.sv
rtl/core/esc_temp.sv
rtl/core/esc_hum.sv
rtl/core/esc_pre.sv
rtl/core/esc_div.sv
rtl/core/esc_post.sv
rtl/core/env_sensor_compensation_top.sv
rtl/core/esc_checker.sv
tb/sv/env_sensor_compensation_top_tb.sv
